// ===== rtl/lsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lsc_pkg;

    localparam int CW = 16;

    localparam logic [3:0] CODE_LEFT   = 4'd1;
    localparam logic [3:0] CODE_RIGHT  = 4'd2;
    localparam logic [3:0] CODE_BOTTOM = 4'd4;
    localparam logic [3:0] CODE_TOP    = 4'd8;
    localparam int MAX_STEPS = 4;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic                 accepted;
        logic signed [CW-1:0] clip_start_x;
        logic signed [CW-1:0] clip_start_y;
        logic signed [CW-1:0] clip_end_x;
        logic signed [CW-1:0] clip_end_y;
    } out_item_t;

    typedef struct packed {
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] bottom;
        logic signed [CW-1:0] right;
        logic signed [CW-1:0] top;
    } window_t;

    typedef struct packed {
        in_item_t   seg;
        logic [3:0] c0;
        logic [3:0] c1;
    } task_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_MUL, ST_DIV, ST_UPDATE, ST_OUT
    } clip_state_t;

    function automatic logic [3:0] region(input logic signed [CW-1:0] x,
                                          input logic signed [CW-1:0] y,
                                          input window_t w);
        logic [3:0] c;
        c = 4'd0;
        if (x < w.left) c = c | CODE_LEFT;
        else if (x > w.right) c = c | CODE_RIGHT;
        if (y < w.bottom) c = c | CODE_BOTTOM;
        else if (y > w.top) c = c | CODE_TOP;
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lsc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lsc_front (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  lsc_pkg::in_item_t     s_data,
    input  lsc_pkg::window_t      win,
    output logic                  q_valid,
    input  wire                   q_ready,
    output lsc_pkg::task_t        q_data
);
    // Two-entry queue of classified requests.
    lsc_pkg::task_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;
    lsc_pkg::task_t t;
    logic           push, pop;

    always_comb begin
        t.seg = s_data;
        t.c0  = lsc_pkg::region(s_data.start_x, s_data.start_y, win);
        t.c1  = lsc_pkg::region(s_data.end_x, s_data.end_y, win);
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= t;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/lsc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lsc_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   q_valid,
    output logic                  q_ready,
    input  lsc_pkg::task_t        q_data,
    input  lsc_pkg::window_t      win,
    output logic                  m_valid,
    input  wire                   m_ready,
    output lsc_pkg::out_item_t    m_data
);
    localparam int CW = lsc_pkg::CW;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int CNTW = $clog2(PW + 1);

    lsc_pkg::clip_state_t state_reg, state_next;

    logic signed [CW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [3:0]           c0_reg, c1_reg;
    logic [2:0]           steps_reg;
    logic [3:0]           co_reg;
    logic signed [CW-1:0] edge_reg;
    logic                 neg_reg, zden_reg;
    logic [DW-1:0]        mag_num_reg, mag_off_reg, mag_den_reg;
    logic [PW-1:0]        quo_reg;
    logic [DW:0]          rem_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic                 out_valid_reg;
    lsc_pkg::out_item_t   out_reg;

    logic [3:0]           co;
    logic signed [CW-1:0] edge_v, a0, b0, b1, e0, e1;
    logic signed [DW-1:0] num, off, den;
    logic [DW:0]          rem_sh;
    logic [PW-1:0]        qv;
    logic signed [CW-1:0] nx, ny, newc;
    logic [3:0]           ncode;
    logic                 start_check, done_acc, done_rej;

    always_comb begin
        co = (c0_reg != 4'd0) ? c0_reg : c1_reg;
        if ((co & lsc_pkg::CODE_TOP) != 4'd0) edge_v = win.top;
        else if ((co & lsc_pkg::CODE_BOTTOM) != 4'd0) edge_v = win.bottom;
        else if ((co & lsc_pkg::CODE_RIGHT) != 4'd0) edge_v = win.right;
        else edge_v = win.left;
        if ((co & (lsc_pkg::CODE_TOP | lsc_pkg::CODE_BOTTOM)) != 4'd0) begin
            b0 = x0_reg; b1 = x1_reg; e0 = y0_reg; e1 = y1_reg;
        end else begin
            b0 = y0_reg; b1 = y1_reg; e0 = x0_reg; e1 = x1_reg;
        end
        a0  = b0;
        num = DW'(b1) - DW'(b0);
        off = DW'(edge_v) - DW'(e0);
        den = DW'(e1) - DW'(e0);
        done_acc = ((c0_reg | c1_reg) == 4'd0);
        done_rej = ((c0_reg & c1_reg) != 4'd0) || (steps_reg >= 3'(lsc_pkg::MAX_STEPS));
        rem_sh = {rem_reg[DW-1:0], quo_reg[PW-1]};
        qv   = neg_reg ? (PW'(0) - quo_reg) : quo_reg;
        newc = zden_reg ? ((co_reg & (lsc_pkg::CODE_TOP | lsc_pkg::CODE_BOTTOM)) != 4'd0
                           ? x0_reg : y0_reg) : CW'(PW'(a0) + qv);
        if ((co_reg & (lsc_pkg::CODE_TOP | lsc_pkg::CODE_BOTTOM)) != 4'd0) begin
            nx = (c0_reg != 4'd0) ? newc : CW'(PW'(x0_reg) + qv);
            ny = edge_reg;
        end else begin
            nx = edge_reg;
            ny = (c0_reg != 4'd0) ? newc : CW'(PW'(y0_reg) + qv);
        end
        if (zden_reg) begin
            if ((co_reg & (lsc_pkg::CODE_TOP | lsc_pkg::CODE_BOTTOM)) != 4'd0)
                nx = (c0_reg != 4'd0) ? x0_reg : x0_reg;
            else
                ny = y0_reg;
        end
        ncode = lsc_pkg::region(nx, ny, win);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lsc_pkg::ST_IDLE: if (q_valid) state_next = lsc_pkg::ST_CHECK;
            lsc_pkg::ST_CHECK: begin
                if (done_acc || done_rej) state_next = lsc_pkg::ST_OUT;
                else state_next = lsc_pkg::ST_MUL;
            end
            lsc_pkg::ST_MUL: state_next = lsc_pkg::ST_DIV;
            lsc_pkg::ST_DIV: if (cnt_reg == CNTW'(0)) state_next = lsc_pkg::ST_UPDATE;
            lsc_pkg::ST_UPDATE: state_next = lsc_pkg::ST_CHECK;
            lsc_pkg::ST_OUT: if (!out_valid_reg) state_next = lsc_pkg::ST_IDLE;
            default: state_next = lsc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_ready     = (state_reg == lsc_pkg::ST_IDLE);
        start_check = (state_reg == lsc_pkg::ST_CHECK);
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        case (state_reg)
            lsc_pkg::ST_IDLE: begin
                x0_reg <= q_data.seg.start_x;
                y0_reg <= q_data.seg.start_y;
                x1_reg <= q_data.seg.end_x;
                y1_reg <= q_data.seg.end_y;
                c0_reg <= q_data.c0;
                c1_reg <= q_data.c1;
                steps_reg <= 3'd0;
            end
            lsc_pkg::ST_CHECK: begin
                co_reg      <= co;
                edge_reg    <= edge_v;
                zden_reg    <= (den == DW'(0));
                neg_reg     <= ((num < 0) != (off < 0)) && (num != 0) && (off != 0)
                               ? !(den < 0) : (den < 0);
                mag_num_reg <= num[DW-1] ? DW'(-num) : DW'(num);
                mag_off_reg <= off[DW-1] ? DW'(-off) : DW'(off);
                mag_den_reg <= den[DW-1] ? DW'(-den) : DW'(den);
            end
            lsc_pkg::ST_MUL: begin
                quo_reg <= PW'(mag_num_reg) * PW'(mag_off_reg);
                rem_reg <= '0;
                cnt_reg <= CNTW'(PW);
            end
            lsc_pkg::ST_DIV: begin
                if (cnt_reg != CNTW'(0)) begin
                    if (rem_sh >= {1'b0, mag_den_reg}) begin
                        rem_reg <= rem_sh - {1'b0, mag_den_reg};
                        quo_reg <= {quo_reg[PW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[PW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CNTW'(1);
                end
            end
            lsc_pkg::ST_UPDATE: begin
                steps_reg <= steps_reg + 3'd1;
                if (c0_reg != 4'd0) begin
                    x0_reg <= nx; y0_reg <= ny; c0_reg <= ncode;
                end else begin
                    x1_reg <= nx; y1_reg <= ny; c1_reg <= ncode;
                end
            end
            default: ;
        endcase
        if (start_check && (done_acc || done_rej)) begin
            out_reg.accepted     <= done_acc;
            out_reg.clip_start_x <= done_acc ? x0_reg : '0;
            out_reg.clip_start_y <= done_acc ? y0_reg : '0;
            out_reg.clip_end_x   <= done_acc ? x1_reg : '0;
            out_reg.clip_end_y   <= done_acc ? y1_reg : '0;
        end
        if (!aresetn) begin
            state_reg     <= lsc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (start_check && (done_acc || done_rej) && !out_valid_reg)
                out_valid_reg <= 1'b1;
            else if (m_valid && m_ready)
                out_valid_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/line_segment_clipper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port      Dir  Payload
// s_*       in   lsc_pkg::in_item_t, one segment per request
// m_*       out  lsc_pkg::out_item_t, one result per request
// cfg_*     in   window register writes, index 0..3
// A request with no clip step is written to the queue, loaded into the back end when idle,
// checked, and its result registered. Each clip step multiplies, runs the serial divider,
// updates the endpoint and checks again.
// The back end takes a new request only after the result of the last one has been taken.
// A stalled result holds the back end; the two-entry queue then fills and s_ready drops.
// Reset is synchronous and active low; it empties the queue and the result.
module line_segment_clipper (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  lsc_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  wire                        m_ready,
    output lsc_pkg::out_item_t         m_data,
    input  wire                        cfg_we,
    input  wire  [1:0]                 cfg_index,
    input  wire  [lsc_pkg::CW-1:0]     cfg_data
);
    lsc_pkg::window_t win_reg;
    logic             q_valid, q_ready;
    lsc_pkg::task_t   q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.left   <= 16'sd100;
            win_reg.bottom <= 16'sd100;
            win_reg.right  <= 16'sd500;
            win_reg.top    <= 16'sd400;
        end else if (cfg_we) begin
            case (cfg_index)
                lsc_pkg::REG_LEFT:   win_reg.left   <= cfg_data;
                lsc_pkg::REG_BOTTOM: win_reg.bottom <= cfg_data;
                lsc_pkg::REG_RIGHT:  win_reg.right  <= cfg_data;
                lsc_pkg::REG_TOP:    win_reg.top    <= cfg_data;
                default: ;
            endcase
        end
    end

    lsc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data), .win(win_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    lsc_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data), .win(win_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    a_rej_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.accepted) |-> (m_data.clip_start_x == '0 &&
        m_data.clip_end_y == '0)) else $error("rejected result not cleared");
    a_no_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (q_valid)) else $error("queue lost a request");
endmodule
`default_nettype wire

// ===== sim/clip_checker.sv =====
`timescale 1ns / 1ps
module clip_checker (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    input  wire                 s_ready,
    input  lsc_pkg::in_item_t   s_data,
    input  wire                 m_valid,
    input  wire                 m_ready,
    input  lsc_pkg::out_item_t  m_data,
    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_index,
    input  wire  [15:0]         cfg_data,
    output int                  fail_count,
    output int                  pending,
    output int                  seen_accepts,
    output int                  seen_rejects
);
    lsc_pkg::window_t win;
    lsc_pkg::out_item_t clip_queue[$];

    function automatic logic [3:0] outcode(longint x, longint y, lsc_pkg::window_t w);
        logic [3:0] c;
        c = 4'd0;
        if (x < longint'(w.left)) c |= lsc_pkg::CODE_LEFT;
        else if (x > longint'(w.right)) c |= lsc_pkg::CODE_RIGHT;
        if (y < longint'(w.bottom)) c |= lsc_pkg::CODE_BOTTOM;
        else if (y > longint'(w.top)) c |= lsc_pkg::CODE_TOP;
        return c;
    endfunction

    function automatic longint edge_cross(longint a0, longint b1, longint c0,
                                          longint c1, longint edge_v);
        longint num, off, den, q, r;
        logic [lsc_pkg::CW-1:0] w;
        num = b1 - a0;
        off = edge_v - c0;
        den = c1 - c0;
        if (den == 0) return a0;
        q = (num * off) / den;
        r = a0 + q;
        w = r[lsc_pkg::CW-1:0];
        return longint'($signed(w));
    endfunction

    function automatic lsc_pkg::out_item_t clip_segment(lsc_pkg::in_item_t seg,
                                                        lsc_pkg::window_t w);
        longint x0, y0, x1, y1, nx, ny;
        logic [3:0] c0, c1, co;
        int steps;
        lsc_pkg::out_item_t res;
        x0 = seg.start_x; y0 = seg.start_y; x1 = seg.end_x; y1 = seg.end_y;
        c0 = outcode(x0, y0, w);
        c1 = outcode(x1, y1, w);
        steps = 0;
        res = '0;
        forever begin
            if ((c0 | c1) == 0) begin
                res.accepted = 1'b1;
                res.clip_start_x = x0[lsc_pkg::CW-1:0];
                res.clip_start_y = y0[lsc_pkg::CW-1:0];
                res.clip_end_x = x1[lsc_pkg::CW-1:0];
                res.clip_end_y = y1[lsc_pkg::CW-1:0];
                break;
            end
            if ((c0 & c1) != 0 || steps >= lsc_pkg::MAX_STEPS) break;
            steps++;
            co = (c0 != 0) ? c0 : c1;
            if (co & lsc_pkg::CODE_TOP) begin
                ny = w.top;
                nx = edge_cross(x0, x1, y0, y1, w.top);
            end else if (co & lsc_pkg::CODE_BOTTOM) begin
                ny = w.bottom;
                nx = edge_cross(x0, x1, y0, y1, w.bottom);
            end else if (co & lsc_pkg::CODE_RIGHT) begin
                nx = w.right;
                ny = edge_cross(y0, y1, x0, x1, w.right);
            end else begin
                nx = w.left;
                ny = edge_cross(y0, y1, x0, x1, w.left);
            end
            if (c0 != 0) begin
                x0 = nx; y0 = ny; c0 = outcode(x0, y0, w);
            end else begin
                x1 = nx; y1 = ny; c1 = outcode(x1, y1, w);
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        lsc_pkg::out_item_t exp_r;
        if (!aresetn) begin
            win <= {16'sd100, 16'sd100, 16'sd500, 16'sd400};
            fail_count <= 0;
            seen_accepts <= 0;
            seen_rejects <= 0;
            pending <= 0;
            clip_queue.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    lsc_pkg::REG_LEFT: win.left <= cfg_data;
                    lsc_pkg::REG_BOTTOM: win.bottom <= cfg_data;
                    lsc_pkg::REG_RIGHT: win.right <= cfg_data;
                    lsc_pkg::REG_TOP: win.top <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) clip_queue.push_back(clip_segment(s_data, win));
            if (m_valid && m_ready) begin
                if (clip_queue.size() == 0) begin
                    $error("Result with no request outstanding: %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = clip_queue.pop_front();
                    if (exp_r.accepted) seen_accepts <= seen_accepts + 1;
                    else seen_rejects <= seen_rejects + 1;
                    if (exp_r !== m_data) begin
                        fail_count <= fail_count + 1;
                        if (exp_r.accepted !== m_data.accepted)
                            $error("accepted: expected %0d, got %0d",
                                   exp_r.accepted, m_data.accepted);
                        if (exp_r.clip_start_x !== m_data.clip_start_x)
                            $error("clip_start_x: expected %0d, got %0d",
                                   exp_r.clip_start_x, m_data.clip_start_x);
                        if (exp_r.clip_start_y !== m_data.clip_start_y)
                            $error("clip_start_y: expected %0d, got %0d",
                                   exp_r.clip_start_y, m_data.clip_start_y);
                        if (exp_r.clip_end_x !== m_data.clip_end_x)
                            $error("clip_end_x: expected %0d, got %0d",
                                   exp_r.clip_end_x, m_data.clip_end_x);
                        if (exp_r.clip_end_y !== m_data.clip_end_y)
                            $error("clip_end_y: expected %0d, got %0d",
                                   exp_r.clip_end_y, m_data.clip_end_y);
                    end
                end
            end
            pending <= clip_queue.size();
        end
    end
endmodule

// ===== sim/tb_line_segment_clipper.sv =====
`timescale 1ns / 1ps
module tb_line_segment_clipper;
    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    lsc_pkg::in_item_t s_data;
    logic m_valid;
    logic m_ready;
    lsc_pkg::out_item_t m_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    int fail_count;
    int pending;
    int seen_accepts;
    int seen_rejects;
    int send_idle_pct;
    int recv_stall_pct;
    int sent;
    longint cycles;

    line_segment_clipper u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    clip_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .seen_accepts(seen_accepts), .seen_rejects(seen_rejects)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_window(input int l, input int b, input int r, input int t);
        write_reg(lsc_pkg::REG_LEFT, l[15:0]);
        write_reg(lsc_pkg::REG_BOTTOM, b[15:0]);
        write_reg(lsc_pkg::REG_RIGHT, r[15:0]);
        write_reg(lsc_pkg::REG_TOP, t[15:0]);
        @(posedge aclk);
    endtask

    task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= {sx[15:0], sy[15:0], ex[15:0], ey[15:0]};
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic int pick(int lo, int hi);
        int r;
        r = $urandom_range(9);
        if (r == 0) return -32768;
        if (r == 1) return 32767;
        if (r < 4) return int'($signed(16'($urandom)));
        return lo - 300 + int'($urandom_range(hi - lo + 600));
    endfunction

    task automatic random_burst(input int n, input int l, input int b,
                                input int r, input int t);
        repeat (n) send_segment(pick(l, r), pick(b, t), pick(l, r), pick(b, t));
    endtask

    initial begin
        cycles = 0;
        sent = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_segment(200, 200, 300, 300);
        send_segment(0, 0, 50, 600);
        send_segment(0, 250, 600, 250);
        send_segment(300, 0, 300, 600);
        send_segment(0, 0, 600, 500);
        send_segment(50, 350, 150, 450);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, -32768, -32768, 32767);
        send_segment(-32768, 200, -32768, 300);
        send_segment(100, 100, 500, 400);
        send_segment(99, 0, 0, 401);
        send_segment(0, 90, 510, 410);
        drain();
        set_window(-32768, -32768, 32767, 32767);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(-1, 32767, 0, -32768);
        drain();
        set_window(300, 300, 200, 200);
        send_segment(0, 0, 600, 600);
        send_segment(250, 0, 250, 600);
        send_segment(-32768, 32767, 32767, -32768);
        drain();
        set_window(7, 7, 7, 7);
        send_segment(0, 0, 14, 14);
        send_segment(7, 7, 7, 7);
        drain();
        write_reg(lsc_pkg::REG_LEFT, 16'd100);

        for (int ph = 0; ph < 8; ph++) begin
            int l, b, r, t;
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 58; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 58; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            l = int'($signed(16'($urandom_range(2000)))) - 1000;
            b = int'($signed(16'($urandom_range(2000)))) - 1000;
            r = l + int'($urandom_range(ph == 5 ? 0 : 1500));
            t = b + int'($urandom_range(1500));
            if (ph == 6) begin l = 400; r = 100; end
            set_window(l, b, r, t);
            random_burst(190, l < r ? l : r, b, l < r ? r : l, t);
            drain();
        end

        $display("Drove %0d segments over several windows and handshake stall mixes;",
                 sent);
        $display("%0d results were visible and %0d were rejected.",
                 seen_accepts, seen_rejects);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== line_segment_clipper.f =====
rtl/lsc_pkg.sv
rtl/lsc_front.sv
rtl/lsc_back.sv
rtl/line_segment_clipper.sv
sim/clip_checker.sv
sim/tb_line_segment_clipper.sv
